// ----- rtl/core/wlps_pkg.sv -----
// ----------------------------------------------------------------------------
// wlps_pkg
// Shared types and constants of the windowed latency percentile tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package wlps_pkg;

  localparam int STAGES_DEF    = 12;
  localparam int RESERVOIR_DEF = 64;

  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 38;
  localparam int COUNT_W  = 7;
  localparam int LANES    = 4;   // median, p95, p99, max
  localparam int PROD_W   = 17;  // holds 99 * (RESERVOIR - 1)
  // floor(x / 100) is approximated by (x * RECIP_100) >> RECIP_SHIFT, then corrected.
  localparam int RECIP_100   = 10485;
  localparam int RECIP_SHIFT = 20;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_REC_RD,
    S_REC_WR,
    S_Q_MUL,
    S_Q_CORR,
    S_SCAN,
    S_DRAIN,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rec_rd;
    logic rec_wr;
    logic q_mul;
    logic q_corr;
    logic scan_rd;
    logic bit_upd;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       stage_ok;
    logic       enabled;
    logic       empty;
    logic       last_issue;
    logic       bit_zero;
    logic       out_free;
  } status_t;

  function automatic int lane_pct(input int lane);
    case (lane)
      0:       return 50;
      1:       return 95;
      default: return 99;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wlps_ram.sv -----
// ----------------------------------------------------------------------------
// wlps_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module wlps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/wlps_ctrl.sv -----
// ----------------------------------------------------------------------------
// wlps_ctrl
// Sequencer for record, clear and query requests.
// ----------------------------------------------------------------------------
`default_nettype none
module wlps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire wlps_pkg::status_t st,
  output wlps_pkg::cmd_t         cmd
);
  import wlps_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        case (st.func)
          FUNC_RECORD: if (st.enabled && st.stage_ok) state_next = S_REC_RD;
          FUNC_QUERY:  state_next = (!st.stage_ok || st.empty) ? S_DONE : S_Q_MUL;
          FUNC_CLEAR:  cmd.clear = 1'b1;
          default:     state_next = S_IDLE;
        endcase
      end
      S_REC_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_REC_WR;
      end
      S_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_Q_MUL: begin
        cmd.q_mul  = 1'b1;
        state_next = S_Q_CORR;
      end
      S_Q_CORR: begin
        cmd.q_corr = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.last_issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.bit_upd = 1'b1;
        state_next  = st.bit_zero ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/wlps_dp.sv -----
// ----------------------------------------------------------------------------
// wlps_dp
// Per-stage rings, sums and counts, radix rank selection and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module wlps_dp #(
  parameter int STAGES    = wlps_pkg::STAGES_DEF,
  parameter int RESERVOIR = wlps_pkg::RESERVOIR_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic [1:0]        s_tuser,
  input  wire logic [39:0]       s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [0:0]             m_tuser,
  output logic [175:0]           m_tdata,
  input  wire wlps_pkg::cmd_t    cmd,
  output wlps_pkg::status_t      st
);
  import wlps_pkg::*;

  localparam int SW    = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int IDX_W = $clog2(RESERVOIR);
  localparam int CNT_W = $clog2(RESERVOIR + 1);
  localparam int AW    = $clog2(STAGES * RESERVOIR);

  logic                record_enable;
  logic [1:0]          func;
  logic [3:0]          stage;
  logic [SAMPLE_W-1:0] sample;

  logic [IDX_W-1:0] ring_head   [STAGES];
  logic [CNT_W-1:0] fill_count  [STAGES];
  logic [SUM_W-1:0] running_sum [STAGES];

  logic [IDX_W-1:0]    scan_idx;
  logic                rd_vld;
  logic [4:0]          bit_idx;
  logic [IDX_W-1:0]    q0     [LANES-1];
  logic [IDX_W-1:0]    rank   [LANES];
  logic [SAMPLE_W-1:0] prefix [LANES];
  logic [CNT_W-1:0]    cnt0   [LANES];

  logic                stage_ok;
  logic [SW-1:0]       stg;
  logic [CNT_W-1:0]    n;
  logic [IDX_W-1:0]    n_m1;
  logic [IDX_W-1:0]    head;
  logic                full;
  logic [AW-1:0]       ram_addr;
  logic [AW:0]         addr_full;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] hi_mask;

  assign stage_ok = ({28'd0, stage} < 32'(STAGES));
  assign stg      = SW'(stage);
  assign n        = stage_ok ? fill_count[stg] : '0;
  assign n_m1     = IDX_W'(n - CNT_W'(1));
  assign head     = ring_head[stg];
  assign full     = (n == CNT_W'(RESERVOIR));
  assign hi_mask  = (32'hFFFF_FFFF << bit_idx) << 1;

  assign addr_full = (AW+1)'(stg) * (AW+1)'(RESERVOIR)
                   + (AW+1)'(cmd.scan_rd ? scan_idx : head);
  assign ram_addr  = addr_full[AW-1:0];

  wlps_ram #(.WIDTH(SAMPLE_W), .DEPTH(STAGES * RESERVOIR)) u_ram (
    .clk   (clk),
    .we    (cmd.rec_wr),
    .addr  (ram_addr),
    .wdata (sample),
    .rdata (ram_rdata)
  );

  always_comb begin
    st.func       = func;
    st.stage_ok   = stage_ok;
    st.enabled    = record_enable;
    st.empty      = (n == '0);
    st.last_issue = (scan_idx == n_m1);
    st.bit_zero   = (bit_idx == 5'd0);
    st.out_free   = !m_tvalid || m_tready;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_enable <= 1'b0;
      for (int s = 0; s < STAGES; s++) begin
        ring_head[s]   <= '0;
        fill_count[s]  <= '0;
        running_sum[s] <= '0;
      end
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) record_enable <= cfg_wdata;
      if (cmd.clear) begin
        for (int s = 0; s < STAGES; s++) begin
          ring_head[s]   <= '0;
          fill_count[s]  <= '0;
          running_sum[s] <= '0;
        end
      end
      if (cmd.rec_wr) begin
        // The old sample at the head leaves the sum only once the ring is full.
        running_sum[stg] <= running_sum[stg] - (full ? SUM_W'(ram_rdata) : '0)
                          + SUM_W'(sample);
        ring_head[stg]   <= (head == IDX_W'(RESERVOIR - 1)) ? '0 : head + IDX_W'(1);
        if (!full) fill_count[stg] <= n + CNT_W'(1);
      end
      rd_vld <= cmd.scan_rd;
      if (cmd.result) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Payload and rank selection registers.
  always_ff @(posedge clk) begin
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] rem;
    if (cmd.load) begin
      func   <= s_tuser;
      stage  <= s_tdata[3:0];
      sample <= s_tdata[35:4];
    end
    if (cmd.q_mul) begin
      for (int l = 0; l < LANES - 1; l++) begin
        q0[l] <= IDX_W'(((32)'(n_m1) * 32'(lane_pct(l) * RECIP_100)) >> RECIP_SHIFT);
      end
    end
    if (cmd.q_corr) begin
      for (int l = 0; l < LANES - 1; l++) begin
        x   = PROD_W'(32'(n_m1) * 32'(lane_pct(l)));
        rem = x - PROD_W'(32'(q0[l]) * 32'd100);
        rank[l] <= (rem >= PROD_W'(100)) ? q0[l] + IDX_W'(1) : q0[l];
      end
      rank[LANES-1] <= n_m1;
      for (int l = 0; l < LANES; l++) begin
        prefix[l] <= '0;
        cnt0[l]   <= '0;
      end
      bit_idx  <= 5'd31;
      scan_idx <= '0;
    end
    if (cmd.scan_rd) scan_idx <= scan_idx + IDX_W'(1);
    if (rd_vld) begin
      // Count samples that share the resolved high bits and have a zero here.
      for (int l = 0; l < LANES; l++) begin
        if ((((ram_rdata ^ prefix[l]) & hi_mask) == '0) && !ram_rdata[bit_idx])
          cnt0[l] <= cnt0[l] + CNT_W'(1);
      end
    end
    if (cmd.bit_upd) begin
      for (int l = 0; l < LANES; l++) begin
        if (CNT_W'(rank[l]) >= cnt0[l]) begin
          prefix[l][bit_idx] <= 1'b1;
          rank[l]            <= rank[l] - IDX_W'(cnt0[l]);
        end
        cnt0[l] <= '0;
      end
      bit_idx  <= bit_idx - 5'd1;
      scan_idx <= '0;
    end
    if (cmd.result) begin
      m_tuser <= !stage_ok;
      if (!stage_ok || n == '0) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {3'd0, prefix[3], prefix[2], prefix[1], prefix[0],
                    running_sum[stg], COUNT_W'(n)};
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/windowed_latency_percentile_stats_top.sv -----
// ----------------------------------------------------------------------------
// windowed_latency_percentile_stats_top
// Sliding-window latency percentile tracker for several pipeline stages.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the function (record,
// query, clear), s_tdata the stage index and the sample. Only a query gives
// a result, on the m_ channel: m_tuser flags a bad stage index, m_tdata holds
// count, window sum, median, p95, p99 and maximum.
// record_enable is written through cfg_we / cfg_wdata; the user writes it only
// while the block is idle, which the block itself does not enforce. Steps per
// request: a record passes accept, dispatch, ring read and write back; a clear or
// an ignored request passes accept and dispatch; a query of an empty or bad stage
// passes accept, dispatch and result. A query finds the ranks one bit at a time,
// with one pass over the ring in the sample RAM for each of 32 bits and one RAM
// read per cycle; the four ranks share each pass.
// The result register lets the next request be taken while a result waits;
// a query that finishes while the receiver stalls holds until it is free.
// Reset (rst, synchronous) empties every ring and clears record_enable.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_latency_percentile_stats_top #(
  parameter int STAGES    = wlps_pkg::STAGES_DEF,
  parameter int RESERVOIR = wlps_pkg::RESERVOIR_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [1:0]   s_tuser,   // func
  input  wire logic [39:0]  s_tdata,   // stage[3:0], sample_value[35:4], zero fill
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [0:0]        m_tuser,   // bad_stage
  output logic [175:0]      m_tdata    // sample_count[6:0], window_total[44:7],
                                       // median[76:45], p95[108:77], p99[140:109],
                                       // max[172:141], zero fill
);
  import wlps_pkg::*;

  cmd_t    cmd;
  status_t st;

  wlps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  wlps_dp #(.STAGES(STAGES), .RESERVOIR(RESERVOIR)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .st        (st)
  );
endmodule
`default_nettype wire

// ----- rtl/core/wlps_chk.sv -----
// ----------------------------------------------------------------------------
// wlps_chk
// Port-level checks of the percentile tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module wlps_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         cfg_we,
  input wire logic         cfg_wdata,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [1:0]   s_tuser,
  input wire logic [39:0]  s_tdata,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [0:0]   m_tuser,
  input wire logic [175:0] m_tdata
);
  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Nothing is presented in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A bad stage index returns all-zero statistics.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("bad stage result not zero");

  // Ranks are ordered: median <= p95 <= p99 <= max.
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[76:45] <= m_tdata[108:77]) &&
                 (m_tdata[108:77] <= m_tdata[140:109]) &&
                 (m_tdata[140:109] <= m_tdata[172:141]))
    else $error("percentiles out of order");
endmodule

bind windowed_latency_percentile_stats_top wlps_chk u_chk (.*);
`default_nettype wire
